### rtl/sset_pkg.sv
package sset_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VERTEX_BITS_DEF = 16;
    localparam int KIND_W          = 2;
    localparam int VERTEX_W        = 16;

    localparam logic [KIND_W-1:0] KIND_ADD_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

    typedef struct packed {
        logic add_first;
        logic add_second;
        logic start;
        logic adv_first;
        logic adv_second;
        logic take;
        logic push;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic heads_equal;
        logic first_less;
        logic out_free;
        logic pend_valid;
    } t_sts;

endpackage

### rtl/sset_ctrl.sv
module sset_ctrl
    import sset_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  t_sts              i_sts,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MERGE  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_kind)
                        KIND_ADD_FIRST:  o_cmd.add_first  = 1'b1;
                        KIND_ADD_SECOND: o_cmd.add_second = 1'b1;
                        KIND_COMPUTE: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_MERGE;
                        end
                        default: ;
                    endcase
                end
            end
            S_MERGE: begin
                if (!i_sts.active) begin
                    n_state = S_FINISH;
                end else if (i_sts.heads_equal) begin
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        o_cmd.adv_first  = 1'b1;
                        o_cmd.adv_second = 1'b1;
                        o_cmd.take       = 1'b1;
                        o_cmd.push       = i_sts.pend_valid;
                    end
                end else if (i_sts.first_less) begin
                    o_cmd.adv_first = 1'b1;
                end else begin
                    o_cmd.adv_second = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/sset_dp.sv
module sset_dp
    import sset_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [VERTEX_W-1:0] i_vertex,
    input  logic                i_out_ready,
    output t_sts                o_sts,
    output logic                o_out_valid,
    output logic [VERTEX_W-1:0] o_common_vertex,
    output logic                o_valid_res,
    output logic                o_last,
    output logic                o_overflowed
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VERTEX_BITS-1:0] r_mem_first [DEPTH];
    logic [VERTEX_BITS-1:0] r_mem_second[DEPTH];

    logic [CW-1:0]          r_cnt_first, r_cnt_second;
    logic [CW-1:0]          r_p_first, r_p_second, n_p_first, n_p_second;
    logic                   r_ovf;
    logic [VERTEX_BITS-1:0] r_a, r_b, r_pend, w_vin;
    logic                   r_pend_valid;
    logic [31:0]            w_vin_wide, w_pend_wide;
    logic                   w_out_free;

    logic                   r_out_valid;
    logic [VERTEX_W-1:0]    r_out_vertex;
    logic                   r_out_vres, r_out_last, r_out_ovf;

    assign w_vin_wide  = 32'(i_vertex);
    assign w_vin       = w_vin_wide[VERTEX_BITS-1:0];
    assign w_pend_wide = 32'(r_pend);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_sts.active      = (r_p_first < r_cnt_first) && (r_p_second < r_cnt_second);
    assign o_sts.heads_equal = (r_a == r_b);
    assign o_sts.first_less  = (r_a < r_b);
    assign o_sts.out_free    = w_out_free;
    assign o_sts.pend_valid  = r_pend_valid;

    always_comb begin
        n_p_first  = r_p_first;
        n_p_second = r_p_second;
        if (i_cmd.start) begin
            n_p_first  = '0;
            n_p_second = '0;
        end else begin
            if (i_cmd.adv_first) begin
                n_p_first = r_p_first + CW'(1);
            end
            if (i_cmd.adv_second) begin
                n_p_second = r_p_second + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_first && (r_cnt_first < CW'(DEPTH))) begin
            r_mem_first[r_cnt_first[AW-1:0]] <= w_vin;
        end
        r_a <= r_mem_first[n_p_first[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_second && (r_cnt_second < CW'(DEPTH))) begin
            r_mem_second[r_cnt_second[AW-1:0]] <= w_vin;
        end
        r_b <= r_mem_second[n_p_second[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_ovf        <= 1'b0;
            r_p_first    <= '0;
            r_p_second   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_p_first  <= n_p_first;
            r_p_second <= n_p_second;
            if (i_cmd.add_first) begin
                if (r_cnt_first < CW'(DEPTH)) begin
                    r_cnt_first <= r_cnt_first + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.add_second) begin
                if (r_cnt_second < CW'(DEPTH)) begin
                    r_cnt_second <= r_cnt_second + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.take) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_cnt_first  <= '0;
                r_cnt_second <= '0;
                r_ovf        <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend <= r_a;
        end
        if (i_cmd.push) begin
            r_out_vertex <= w_pend_wide[VERTEX_W-1:0];
            r_out_vres   <= 1'b1;
            r_out_last   <= 1'b0;
            r_out_ovf    <= r_ovf;
        end else if (i_cmd.finish) begin
            r_out_vertex <= r_pend_valid ? w_pend_wide[VERTEX_W-1:0] : '0;
            r_out_vres   <= r_pend_valid;
            r_out_last   <= 1'b1;
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_common_vertex = r_out_vertex;
    assign o_valid_res     = r_out_vres;
    assign o_last          = r_out_last;
    assign o_overflowed    = r_out_ovf;

endmodule

### rtl/sorted_set_intersection.sv
// Collects two ascending vertex lists of up to DEPTH entries each, one add item per cycle
// while idle, and on a compute item walks them with a two-pointer merge, returning every
// common vertex as one result with the final one marked last, or a single not-valid last
// result when nothing matches; both lists and the overflow flag are then cleared. A compute
// item starts the merge, advances the pointers in at most the count of the first list plus
// the count of the second list minus one merge steps, sees a list run out and issues the
// last result, and only then is the next item accepted; each step is one registered read
// of both list memories at the advanced pointers. A match step holding an earlier match,
// and the last result, wait while the result register is full and not being taken.
module sorted_set_intersection
    import sset_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [VERTEX_W-1:0] i_vertex,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VERTEX_W-1:0] o_common_vertex,
    output logic                o_valid_res,
    output logic                o_last,
    output logic                o_overflowed
);

    t_cmd w_cmd;
    t_sts w_sts;

    sset_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    sset_dp #(
        .DEPTH       (DEPTH),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_vertex        (i_vertex),
        .i_out_ready     (i_out_ready),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_common_vertex (o_common_vertex),
        .o_valid_res     (o_valid_res),
        .o_last          (o_last),
        .o_overflowed    (o_overflowed)
    );

endmodule

### dv/sorted_set_intersection_tb.sv
module sorted_set_intersection_tb;
    import sset_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int TARGET_ITEMS = 370;
    localparam int QUIET_ITEMS  = 310;
    localparam int DIR_ROWS     = 24;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [VERTEX_W-1:0] vtx;
        logic                vld;
        logic                lst;
        logic                ovf;
    } t_isect_result;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VERTEX_W-1:0] vertex;
        logic                typed;
        t_isect_result       res;
    } t_stim_row;

    localparam t_isect_result NO_RESULT    = '0;
    localparam t_isect_result EMPTY_RESULT = '{vtx: 16'h0000, vld: 1'b0, lst: 1'b1, ovf: 1'b0};

    // Rows marked typed carry their expected result; the rest go through the predictor.
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        '{KIND_COMPUTE,    16'hffff, 1'b1, EMPTY_RESULT},
        '{KIND_ADD_FIRST,  16'h0000, 1'b0, NO_RESULT},
        '{KIND_ADD_FIRST,  16'hffff, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'h0000, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'hffff, 1'b0, NO_RESULT},
        '{KIND_COMPUTE,    16'h0000, 1'b0, NO_RESULT},
        '{KIND_ADD_FIRST,  16'h5555, 1'b0, NO_RESULT},
        '{KIND_UNUSED,     16'haaaa, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'haaaa, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'h5555, 1'b0, NO_RESULT},
        '{KIND_COMPUTE,    16'h1234, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'h0003, 1'b0, NO_RESULT},
        '{KIND_COMPUTE,    16'h0000, 1'b1, EMPTY_RESULT},
        '{KIND_ADD_FIRST,  16'h0009, 1'b0, NO_RESULT},
        '{KIND_ADD_FIRST,  16'h0002, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'h0002, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'h0009, 1'b0, NO_RESULT},
        '{KIND_COMPUTE,    16'h0000, 1'b0, NO_RESULT},
        '{KIND_ADD_FIRST,  16'h0007, 1'b0, NO_RESULT},
        '{KIND_UNUSED,     16'h0007, 1'b0, NO_RESULT},
        '{KIND_ADD_SECOND, 16'h0007, 1'b0, NO_RESULT},
        '{KIND_COMPUTE,    16'h0000, 1'b0, NO_RESULT},
        '{KIND_ADD_FIRST,  16'h0001, 1'b0, NO_RESULT},
        '{KIND_COMPUTE,    16'h0000, 1'b1, EMPTY_RESULT}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [KIND_W-1:0]   i_kind      = KIND_ADD_FIRST;
    logic [VERTEX_W-1:0] i_vertex    = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [VERTEX_W-1:0] o_common_vertex;
    logic                o_valid_res;
    logic                o_last;
    logic                o_overflowed;

    logic [VERTEX_W-1:0] first_list [DEPTH];
    logic [VERTEX_W-1:0] second_list [DEPTH];
    int                  first_len    = 0;
    int                  second_len   = 0;
    logic                drop_flag    = 1'b0;
    t_isect_result       merge_out [$];
    t_isect_result       pending_results [$];
    t_isect_result       want_res;
    t_isect_result       got_res;
    int                  fail_count   = 0;
    int                  items_sent   = 0;
    int                  hold_request = 0;
    logic                quiet        = 1'b0;

    sorted_set_intersection u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_vertex       (i_vertex),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_common_vertex(o_common_vertex),
        .o_valid_res    (o_valid_res),
        .o_last         (o_last),
        .o_overflowed   (o_overflowed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void intersect_predict(input logic [KIND_W-1:0] kind,
                                              input logic [VERTEX_W-1:0] vertex);
        int            p1;
        int            p2;
        t_isect_result r;
        p1 = 0;
        p2 = 0;
        merge_out.delete();
        case (kind)
            KIND_ADD_FIRST: begin
                if (first_len >= DEPTH) begin
                    drop_flag = 1'b1;
                end else begin
                    first_list[first_len] = vertex;
                    first_len++;
                end
            end
            KIND_ADD_SECOND: begin
                if (second_len >= DEPTH) begin
                    drop_flag = 1'b1;
                end else begin
                    second_list[second_len] = vertex;
                    second_len++;
                end
            end
            KIND_COMPUTE: begin
                while (p1 < first_len && p2 < second_len) begin
                    if (first_list[p1] == second_list[p2]) begin
                        r = '{vtx: first_list[p1], vld: 1'b1, lst: 1'b0, ovf: drop_flag};
                        merge_out.push_back(r);
                        p1++;
                        p2++;
                    end else if (first_list[p1] < second_list[p2]) begin
                        p1++;
                    end else begin
                        p2++;
                    end
                end
                if (merge_out.size() == 0) begin
                    r = '{vtx: '0, vld: 1'b0, lst: 1'b1, ovf: drop_flag};
                end else begin
                    r = merge_out.pop_back();
                    r.lst = 1'b1;
                end
                merge_out.push_back(r);
                first_len  = 0;
                second_len = 0;
                drop_flag  = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [VERTEX_W-1:0] vertex,
                              input logic typed, input t_isect_result typed_res);
        if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 8));
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_vertex   <= vertex;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        intersect_predict(kind, vertex);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            foreach (merge_out[k]) pending_results.push_back(merge_out[k]);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One set pair: candidates rise monotonically and land in the first list, the second
    // list or both, so the lists stay sorted and overlap. Some sets are unsorted noise.
    task automatic run_random_set();
        logic [VERTEX_W-1:0] a_q [$];
        logic [VERTEX_W-1:0] b_q [$];
        int                  shape;
        int                  n_cand;
        int                  max_step;
        int                  v;
        int                  pick;
        shape = $urandom_range(0, 9);
        n_cand = (shape == 1) ? $urandom_range(20, 48) : $urandom_range(0, 10);
        case ($urandom_range(0, 2))
            0: max_step = 1;
            1: max_step = 4;
            default: max_step = 1200;
        endcase
        v = $urandom_range(0, 65535 - n_cand * max_step);
        for (int i = 0; i < n_cand; i++) begin
            if (shape == 0) begin
                v = $urandom_range(0, 15);
            end else begin
                v = v + $urandom_range(1, max_step);
            end
            pick = $urandom_range(0, 3);
            if (pick != 1) a_q.push_back(v[VERTEX_W-1:0]);
            if (pick != 0) b_q.push_back(v[VERTEX_W-1:0]);
        end
        while (a_q.size() != 0 || b_q.size() != 0) begin
            if ($urandom_range(0, 19) == 0) begin
                offer_item(KIND_UNUSED, VERTEX_W'($urandom_range(0, 65535)), 1'b0, NO_RESULT);
            end
            if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(0, 1) == 0)) begin
                offer_item(KIND_ADD_FIRST, a_q.pop_front(), 1'b0, NO_RESULT);
            end else begin
                offer_item(KIND_ADD_SECOND, b_q.pop_front(), 1'b0, NO_RESULT);
            end
        end
        offer_item(KIND_COMPUTE, VERTEX_W'($urandom_range(0, 65535)), 1'b0, NO_RESULT);
    endtask

    initial begin : sink_ready_gen
        int   burst;
        logic lvl;
        burst = 0;
        lvl   = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                burst        = hold_request;
                lvl          = 1'b0;
                hold_request = 0;
            end else if (burst <= 0) begin
                if (quiet) begin
                    lvl   = 1'b1;
                    burst = 1;
                end else if ($urandom_range(0, 2) == 0) begin
                    lvl   = 1'b0;
                    burst = $urandom_range(1, 8);
                end else begin
                    lvl   = 1'b1;
                    burst = $urandom_range(1, 16);
                end
            end
            i_out_ready <= lvl;
            burst--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = '{vtx: o_common_vertex, vld: o_valid_res, lst: o_last, ovf: o_overflowed};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: vertex=%h valid=%b last=%b ovf=%b",
                         $time, got_res.vtx, got_res.vld, got_res.lst, got_res.ovf);
                fail_count++;
            end else begin
                want_res = pending_results.pop_front();
                if (got_res !== want_res) begin
                    $display({"%0t: result mismatch: expected vertex=%h valid=%b last=%b ",
                              "ovf=%b, actual vertex=%h valid=%b last=%b ovf=%b"},
                             $time, want_res.vtx, want_res.vld, want_res.lst, want_res.ovf,
                             got_res.vtx, got_res.vld, got_res.lst, got_res.ovf);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            offer_item(row.kind, row.vertex, row.typed, row.res);
        end

        // Fully overlapping lists, the first one overfilled, with the receiver held off so
        // the results back up while further adds keep arriving.
        for (int i = 0; i < DEPTH + 2; i++) begin
            offer_item(KIND_ADD_FIRST, 16'(100 + 7 * i), 1'b0, NO_RESULT);
        end
        for (int i = 0; i < DEPTH; i++) begin
            offer_item(KIND_ADD_SECOND, 16'(100 + 7 * i), 1'b0, NO_RESULT);
        end
        hold_request = HOLD_CYCLES;
        offer_item(KIND_COMPUTE, 16'h0000, 1'b0, NO_RESULT);
        for (int i = 0; i < 6; i++) begin
            offer_item(i[0] ? KIND_ADD_SECOND : KIND_ADD_FIRST, 16'(40 * i), 1'b0, NO_RESULT);
        end
        wait_drained();

        while (items_sent < TARGET_ITEMS) begin
            if (items_sent >= QUIET_ITEMS) quiet = 1'b1;
            run_random_set();
        end

        wait_drained();
        repeat (4 * DEPTH + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(20 * 400000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/sset_pkg.sv
rtl/sset_ctrl.sv
rtl/sset_dp.sv
rtl/sorted_set_intersection.sv
dv/sorted_set_intersection_tb.sv
